@@ rtl/bounded_stack_with_search_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bounded stack block
// Shared wrappers for the concurrent checks kept at the end of the top module.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_SEARCH_TOP_ASSERT_SVH
`define BOUNDED_STACK_WITH_SEARCH_TOP_ASSERT_SVH

// Check on every clock edge, masked while reset is asserted
`define BSS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define BSS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bss_pkg.sv @@
// ----------------------------------------------------------------------------
// bss_pkg
// Types and codes shared by the stack cells and the stack top level.
// ----------------------------------------------------------------------------
package bss_pkg;

	// Width of the word fields on the ports
	localparam int unsigned VALUE_W = 32;

	// Request kinds
	localparam logic [1:0] ACT_PUSH   = 2'd0;
	localparam logic [1:0] ACT_POP    = 2'd1;
	localparam logic [1:0] ACT_PEEK   = 2'd2;
	localparam logic [1:0] ACT_SEARCH = 2'd3;

	// Request item
	typedef struct packed {
		logic [1:0]         action;
		logic [VALUE_W-1:0] value;
	} req_t;

	// Result item
	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] top_value;
		logic               found;
		logic               is_empty;
		logic               is_full;
	} rsp_t;

	// Broadcast control for every cell of the chain
	typedef struct packed {
		logic push;   // shift words one cell away from the top
		logic pop;    // shift words one cell toward the top
		logic clr;    // clear the search hit chain
		logic scan;   // advance the search hit chain one cell
	} cell_ctrl_t;

endpackage

@@ rtl/bss_cell.sv @@
// ----------------------------------------------------------------------------
// bss_cell
// One stack slot: holds a word, shifts it with its neighbors on push and pop,
// and ripples the search hit flag toward the top of the stack.
// ----------------------------------------------------------------------------
module bss_cell #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bss_pkg::cell_ctrl_t    ctrl,
	input  logic                   occupied,
	input  logic [DATA_WIDTH-1:0]  target,
	input  logic [DATA_WIDTH-1:0]  above_data,
	input  logic [DATA_WIDTH-1:0]  below_data,
	input  logic                   below_hit,
	output logic [DATA_WIDTH-1:0]  data,
	output logic                   hit
);
	import bss_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  hit_q;
	logic                  match;

	// Compare the held word against the search target
	assign match = occupied && (data_q == target);

	// Shift the word down on push, up on pop, else hold
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			data_q <= above_data;
		end else if (ctrl.pop) begin
			data_q <= below_data;
		end
	end

	// Collect hits from this cell and every cell below it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.clr) begin
			hit_q <= 1'b0;
		end else if (ctrl.scan) begin
			hit_q <= match | below_hit;
		end
	end

	assign data = data_q;
	assign hit  = hit_q;

endmodule

@@ rtl/bounded_stack_with_search_top.sv @@
// Push, pop and peek each give a registered result: one item per cycle while no search or
// stalled result holds the input. A search on N entries scans while the hit flag ripples
// one cell per cycle toward the top, then gives its result; the next item is taken only after
// that result is loaded. A search on an empty stack gives its result without a scan.
// A waiting result blocks new items only while stalled. Reset clears the entry count, the
// search state and the result valid; slot words are never read before a push writes them.
`include "bounded_stack_with_search_top_assert.svh"
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top
// Bounded LIFO of DEPTH words built as a chain of shifting cells, with a
// push, pop, peek and search-for-value request per item.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_top #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bss_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bss_pkg::rsp_t  rsp
);
	import bss_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                  state_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         steps_q;
	logic [DATA_WIDTH-1:0] target_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  req_acc;
	logic                  out_free;
	logic                  is_empty;
	logic                  is_full;
	logic [DATA_WIDTH-1:0] word;
	logic [VALUE_W-1:0]    top_word;
	cell_ctrl_t            ctrl;
	logic                  load;
	rsp_t                  load_rsp;
	logic [CW-1:0]         count_d;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic                  cell_hit  [DEPTH];

	// Handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !out_free;
	assign req_acc   = req_valid && !req_stall;

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));

	// Fit the port word to the slot width and back
	if (DATA_WIDTH <= VALUE_W) begin : g_narrow
		assign word     = req.value[DATA_WIDTH-1:0];
		assign top_word = VALUE_W'(cell_data[0]);
	end else begin : g_wide
		assign word     = {{(DATA_WIDTH-VALUE_W){1'b0}}, req.value};
		assign top_word = cell_data[0][VALUE_W-1:0];
	end

	// Chain of slots, top of stack in cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] above;
		logic [DATA_WIDTH-1:0] below;
		logic                  below_hit;

		if (i == 0) begin : g_first
			assign above = word;
		end else begin : g_mid_a
			assign above = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign below     = cell_data[i];
			assign below_hit = 1'b0;
		end else begin : g_mid_b
			assign below     = cell_data[i+1];
			assign below_hit = cell_hit[i+1];
		end

		bss_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.occupied   (count_q > CW'(i)),
			.target     (target_q),
			.above_data (above),
			.below_data (below),
			.below_hit  (below_hit),
			.data       (cell_data[i]),
			.hit        (cell_hit[i])
		);
	end

	// Decode the accepted item and the search finish
	always_comb begin
		ctrl     = '0;
		load     = 1'b0;
		load_rsp = '0;
		count_d  = count_q;
		if (state_q == ST_SCAN) begin
			if (steps_q != '0) begin
				ctrl.scan = 1'b1;
			end else if (out_free) begin
				load              = 1'b1;
				load_rsp.ok       = 1'b1;
				load_rsp.found    = cell_hit[0];
			end
		end else if (req_acc) begin
			unique case (req.action)
				ACT_PUSH: begin
					load = 1'b1;
					if (!is_full) begin
						ctrl.push   = 1'b1;
						count_d     = count_q + CW'(1);
						load_rsp.ok = 1'b1;
					end
				end
				ACT_POP: begin
					load = 1'b1;
					if (!is_empty) begin
						ctrl.pop    = 1'b1;
						count_d     = count_q - CW'(1);
						load_rsp.ok = 1'b1;
					end
				end
				ACT_PEEK: begin
					load = 1'b1;
					if (!is_empty) begin
						load_rsp.ok        = 1'b1;
						load_rsp.top_value = top_word;
					end
				end
				ACT_SEARCH: begin
					ctrl.clr = 1'b1;
					if (is_empty) begin
						load        = 1'b1;
						load_rsp.ok = 1'b1;
					end
				end
				default: begin
					load = 1'b0;
				end
			endcase
		end
		load_rsp.is_empty = (count_d == '0);
		load_rsp.is_full  = (count_d == CW'(DEPTH));
	end

	// Advance count, search sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			steps_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (state_q == ST_SCAN) begin
				if (steps_q != '0) begin
					steps_q <= steps_q - CW'(1);
				end else if (out_free) begin
					state_q <= ST_IDLE;
				end
			end else if (req_acc && (req.action == ACT_SEARCH) && !is_empty) begin
				state_q <= ST_SCAN;
				steps_q <= count_q;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the search target and the result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			target_q <= word;
		end
		if (load) begin
			rsp_q <= load_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`BSS_ASSERT_ALWAYS(a_scan_blocks_req,
		(state_q == ST_SCAN) |-> req_stall,
		"request taken during search")
	`BSS_ASSERT(a_push_counts,
		(req_acc && req.action == ACT_PUSH && !is_full) |=>
			(count_q == $past(count_q) + CW'(1)),
		"push did not grow the stack")
	`BSS_ASSERT(a_flags_track,
		rsp_valid_q |-> ((rsp_q.is_full == is_full) && (rsp_q.is_empty == is_empty)),
		"result flags disagree with count")
	`BSS_ASSERT(a_scan_bound,
		(state_q == ST_SCAN) |-> (steps_q <= count_q),
		"search steps exceed entry count")

endmodule
